// File: rtl/core/three_way_mix_ratio_ramp_top_assert.svh
// ---------------------------------------------------------------------------
// Mix ratio ramp assertion macros
// Shared concurrent assertion forms for the ramp RTL. The user module
// provides clk and rst.
// ---------------------------------------------------------------------------
`ifndef THREE_WAY_MIX_RATIO_RAMP_TOP_ASSERT_SVH
`define THREE_WAY_MIX_RATIO_RAMP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWMRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWMRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/twmrr_pkg.sv
// ---------------------------------------------------------------------------
// Mix ratio ramp package
// Widths, command codes, register map, configuration type and the small
// arithmetic helpers used by the ramp datapath.
// ---------------------------------------------------------------------------
package twmrr_pkg;

  localparam int MIX_W           = 7;
  localparam int LPS_W           = 16;
  localparam int CMD_W           = 2;
  localparam int CH_W            = 2;
  localparam int PARAM_W         = 10;
  localparam int PROD_W          = 2 * MIX_W;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LINE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_START_A = 3'd0;
  localparam logic [2:0] REG_START_B = 3'd1;
  localparam logic [2:0] REG_START_C = 3'd2;
  localparam logic [2:0] REG_END_A   = 3'd3;
  localparam logic [2:0] REG_END_B   = 3'd4;
  localparam logic [2:0] REG_END_C   = 3'd5;
  localparam logic [2:0] REG_LPS     = 3'd6;

  // Register reset values.
  localparam logic [MIX_W-1:0] RST_START_A = 7'd100;
  localparam logic [MIX_W-1:0] RST_START_B = 7'd0;
  localparam logic [MIX_W-1:0] RST_START_C = 7'd0;
  localparam logic [MIX_W-1:0] RST_END_A   = 7'd100;
  localparam logic [MIX_W-1:0] RST_END_B   = 7'd0;
  localparam logic [MIX_W-1:0] RST_END_C   = 7'd0;
  localparam logic [LPS_W-1:0] RST_LPS     = 16'd1;

  localparam logic [PARAM_W-1:0] PARAM_BASE   = 10'd945;
  localparam logic [PARAM_W-1:0] PARAM_STRIDE = 10'd4;
  localparam logic [MIX_W-1:0]   MIX_MAX      = 7'd127;

  typedef logic [2:0][MIX_W-1:0] mix3_t;

  typedef struct packed {
    mix3_t            start_mix;
    mix3_t            end_mix;
    logic [LPS_W-1:0] lines_per_step;
  } twmrr_cfg_t;

  // Distance between two percentages.
  function automatic logic [MIX_W-1:0] abs_diff(input logic [MIX_W-1:0] a,
                                                input logic [MIX_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // One unit toward the end value, held inside 0 to 127.
  function automatic logic [MIX_W-1:0] step_toward(input logic [MIX_W-1:0] now,
                                                   input logic [MIX_W-1:0] first,
                                                   input logic [MIX_W-1:0] last_v);
    logic [MIX_W-1:0] res;
    res = now;
    if (last_v > first) begin
      if (now != MIX_MAX) res = now + 7'd1;
    end else if (last_v < first) begin
      if (now != '0) res = now - 7'd1;
    end
    return res;
  endfunction

  // Next channel in the cyclic order.
  function automatic logic [CH_W-1:0] next_ch(input logic [CH_W-1:0] ch);
    return (ch == 2'd0) ? 2'd1 : ((ch == 2'd1) ? 2'd2 : 2'd0);
  endfunction

  // Rotate so that element 0 is channel r, 1 the one after, 2 the one after that.
  function automatic mix3_t rot3(input mix3_t v, input logic [CH_W-1:0] r);
    mix3_t res;
    case (r)
      2'd1:    res = {v[0], v[2], v[1]};
      2'd2:    res = {v[1], v[0], v[2]};
      default: res = v;
    endcase
    return res;
  endfunction

  function automatic logic [PARAM_W-1:0] param_of(input logic [CH_W-1:0] ch);
    return PARAM_BASE + PARAM_STRIDE * PARAM_W'(ch);
  endfunction

endpackage

// File: rtl/core/twmrr_cmd_if.sv
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one program command per transfer.
// ---------------------------------------------------------------------------
interface twmrr_cmd_if import twmrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic             is_move;

  modport source (output valid, output cmd, output is_move, input ready);
  modport sink (input valid, input cmd, input is_move, output ready);
endinterface

// File: rtl/core/twmrr_mix_if.sv
// ---------------------------------------------------------------------------
// Mix setting channel
// Valid/ready channel that carries one channel mix setting per transfer.
// ---------------------------------------------------------------------------
interface twmrr_mix_if import twmrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel;
  logic [PARAM_W-1:0] param_number;
  logic [MIX_W-1:0]   mix_percent;
  logic               last;

  modport source (output valid, output channel, output param_number,
                  output mix_percent, output last, input ready);
  modport sink (input valid, input channel, input param_number,
                input mix_percent, input last, output ready);
endinterface

// File: rtl/core/twmrr_ramp.sv
// ---------------------------------------------------------------------------
// Mix ratio ramp datapath
// Command register, ramp state, one pass of step logic and a result
// buffer of up to three settings that drains one transfer per cycle while the output is ready.
// ---------------------------------------------------------------------------
`include "three_way_mix_ratio_ramp_top_assert.svh"

module twmrr_ramp import twmrr_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  twmrr_cfg_t    cfg,
  twmrr_cmd_if.sink     cmd_ch,
  twmrr_mix_if.source   mix_ch
);

  localparam int CMP_W = (COUNT_WIDTH > LPS_W) ? COUNT_WIDTH : LPS_W;

  // Command register.
  logic             s1_valid;
  logic [CMD_W-1:0] s1_cmd;
  logic             s1_is_move;

  // Ramp state.
  mix3_t                  mix_now;
  logic [COUNT_WIDTH-1:0] move_count;
  logic [CH_W-1:0]        lead_channel;
  logic                   ramp_done;

  // Result buffer.
  logic                         bundle_valid;
  logic [1:0]                   bundle_cnt;
  logic [1:0]                   bundle_idx;
  logic [2:0][CH_W-1:0]         bundle_ch;
  mix3_t                        bundle_pct;

  logic out_fire;
  logic bundle_last;
  logic bundle_free;
  logic bundle_load;
  logic s1_adv;
  logic [1:0] nres;

  // Begin: lead channel selection.
  logic [MIX_W-1:0] a0, a1, a2, a_lead1;
  logic [CH_W-1:0]  lead1, begin_lead;

  assign a0      = abs_diff(cfg.end_mix[0], cfg.start_mix[0]);
  assign a1      = abs_diff(cfg.end_mix[1], cfg.start_mix[1]);
  assign a2      = abs_diff(cfg.end_mix[2], cfg.start_mix[2]);
  assign lead1   = (a1 > a0) ? 2'd1 : 2'd0;
  assign a_lead1 = (a1 > a0) ? a1 : a0;
  assign begin_lead = (a2 > a_lead1) ? 2'd2 : lead1;

  // Move counter and step trigger.
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_cmp, lps_cmp;
  logic                   step_hit;
  logic                   is_step;

  assign cnt_inc  = move_count + COUNT_WIDTH'(1);
  assign cnt_cmp  = CMP_W'(cnt_inc);
  assign lps_cmp  = CMP_W'(cfg.lines_per_step);
  assign step_hit = !ramp_done && (cfg.lines_per_step != '0) && (cnt_cmp == lps_cmp);
  assign is_step  = (s1_cmd == CMD_LINE) && s1_is_move && step_hit;

  // Step: values seen from the lead channel (0 lead, 1 second, 2 third).
  mix3_t            r_now, r_start, r_end;
  logic [CH_W-1:0]  sec_ch, thr_ch, behind_ch;
  logic [MIX_W-1:0] lead_new, d2, d3, n2, n3, d2e, d3e;
  logic [PROD_W-1:0] p2, p3;
  logic             behind_sec, behind_zero;
  logic [MIX_W-1:0] behind_new;

  assign r_now   = rot3(mix_now, lead_channel);
  assign r_start = rot3(cfg.start_mix, lead_channel);
  assign r_end   = rot3(cfg.end_mix, lead_channel);
  assign sec_ch  = next_ch(lead_channel);
  assign thr_ch  = next_ch(sec_ch);

  assign lead_new = step_toward(r_now[0], r_start[0], r_end[0]);

  // Finished fractions, compared by cross-multiplication.
  assign d2  = abs_diff(r_end[1], r_start[1]);
  assign d3  = abs_diff(r_end[2], r_start[2]);
  assign n2  = (d2 == '0) ? 7'd1 : abs_diff(r_now[1], r_start[1]);
  assign n3  = (d3 == '0) ? 7'd1 : abs_diff(r_now[2], r_start[2]);
  assign d2e = (d2 == '0) ? 7'd1 : d2;
  assign d3e = (d3 == '0) ? 7'd1 : d3;
  assign p2  = PROD_W'(n2) * PROD_W'(d3e);
  assign p3  = PROD_W'(n3) * PROD_W'(d2e);

  assign behind_sec  = (p2 <= p3);
  assign behind_ch   = behind_sec ? sec_ch : thr_ch;
  assign behind_zero = behind_sec ? (d2 == '0) : (d3 == '0);
  assign behind_new  = behind_sec ? step_toward(r_now[1], r_start[1], r_end[1])
                                  : step_toward(r_now[2], r_start[2], r_end[2]);

  // Number of settings this command produces.
  always_comb begin
    nres = 2'd0;
    if (s1_cmd == CMD_BEGIN || s1_cmd == CMD_END) begin
      nres = 2'd3;
    end else if (is_step) begin
      nres = behind_zero ? 2'd1 : 2'd2;
    end
  end

  // Handshake between the command register and the result buffer.
  assign out_fire     = bundle_valid && mix_ch.ready;
  assign bundle_last  = (bundle_idx == bundle_cnt - 2'd1);
  assign bundle_free  = !bundle_valid || (out_fire && bundle_last);
  assign s1_adv       = s1_valid && ((nres == 2'd0) || bundle_free);
  assign bundle_load  = s1_adv && (nres != 2'd0);
  assign cmd_ch.ready = !s1_valid || s1_adv;

  // Command register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      s1_valid <= cmd_ch.valid;
    end
    if (cmd_ch.valid && cmd_ch.ready) begin
      s1_cmd     <= cmd_ch.cmd;
      s1_is_move <= cmd_ch.is_move;
    end
  end

  // Ramp state update, one command per cycle while the command register can advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_now      <= '0;
      move_count   <= '0;
      lead_channel <= '0;
      ramp_done    <= 1'b1;
    end else if (s1_adv) begin
      if (s1_cmd == CMD_BEGIN) begin
        mix_now      <= cfg.start_mix;
        lead_channel <= begin_lead;
        move_count   <= '0;
        ramp_done    <= (a0 == '0) && (a1 == '0) && (a2 == '0);
      end else if (s1_cmd == CMD_END) begin
        ramp_done <= 1'b1;
      end else if (s1_cmd == CMD_LINE && s1_is_move) begin
        move_count <= step_hit ? '0 : cnt_inc;
        if (step_hit) begin
          for (int ch = 0; ch < 3; ch++) begin
            if (CH_W'(ch) == lead_channel) begin
              mix_now[ch] <= lead_new;
            end else if (CH_W'(ch) == behind_ch && !behind_zero) begin
              mix_now[ch] <= behind_new;
            end
          end
          if (lead_new == r_end[0]) ramp_done <= 1'b1;
        end
      end
    end
  end

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      bundle_valid <= 1'b0;
      bundle_idx   <= '0;
      bundle_cnt   <= '0;
    end else if (bundle_load) begin
      bundle_valid <= 1'b1;
      bundle_idx   <= '0;
      bundle_cnt   <= nres;
    end else if (out_fire) begin
      if (bundle_last) begin
        bundle_valid <= 1'b0;
      end else begin
        bundle_idx <= bundle_idx + 2'd1;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (bundle_load) begin
      if (s1_cmd == CMD_BEGIN || s1_cmd == CMD_END) begin
        bundle_ch  <= {2'd2, 2'd1, 2'd0};
        bundle_pct <= (s1_cmd == CMD_BEGIN) ? cfg.start_mix : mix_now;
      end else begin
        bundle_ch  <= {2'd0, behind_ch, lead_channel};
        bundle_pct <= {7'd0, behind_new, lead_new};
      end
    end
  end

  // Output transfer.
  assign mix_ch.valid        = bundle_valid;
  assign mix_ch.channel      = bundle_ch[bundle_idx];
  assign mix_ch.param_number = param_of(bundle_ch[bundle_idx]);
  assign mix_ch.mix_percent  = bundle_pct[bundle_idx];
  assign mix_ch.last         = bundle_last;

  // Checks.
  `TWMRR_ASSERT_SAME(a_lead_in_range, 1'b1, lead_channel != 2'd3,
                     "lead channel out of range")
  `TWMRR_ASSERT_SAME(a_idx_in_range, bundle_valid, bundle_idx < bundle_cnt,
                     "result index past result count")
  `TWMRR_ASSERT_SAME(a_no_step_when_done, s1_adv && s1_cmd == CMD_LINE && ramp_done,
                     !bundle_load, "ramp stepped after it finished")
  `TWMRR_ASSERT_NEXT(a_drain_empties, out_fire && bundle_last && !bundle_load,
                     !bundle_valid, "result buffer not empty after final transfer")

endmodule

// File: rtl/core/three_way_mix_ratio_ramp_top.sv
// A command is held in the command register; its settings are loaded into
// the result buffer. A command with no setting does not wait for the buffer;
// begin and end load three settings, a ramp step one or two. The buffer drains
// one transfer per cycle while mix_ch is ready and so sets the sustained rate.
// Reset (rst, synchronous): registers return to their defaults, mixes to zero,
// the ramp is idle.
// ---------------------------------------------------------------------------
// Mix ratio ramp top level
// Configuration registers on an APB-style port and the ramp datapath.
// ---------------------------------------------------------------------------
module three_way_mix_ratio_ramp_top import twmrr_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  twmrr_cmd_if.sink             cmd_ch,
  twmrr_mix_if.source           mix_ch
);

  twmrr_cfg_t cfg;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mix      <= {RST_START_C, RST_START_B, RST_START_A};
      cfg.end_mix        <= {RST_END_C, RST_END_B, RST_END_A};
      cfg.lines_per_step <= RST_LPS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_A: cfg.start_mix[0]      <= pwdata[MIX_W-1:0];
        REG_START_B: cfg.start_mix[1]      <= pwdata[MIX_W-1:0];
        REG_START_C: cfg.start_mix[2]      <= pwdata[MIX_W-1:0];
        REG_END_A:   cfg.end_mix[0]        <= pwdata[MIX_W-1:0];
        REG_END_B:   cfg.end_mix[1]        <= pwdata[MIX_W-1:0];
        REG_END_C:   cfg.end_mix[2]        <= pwdata[MIX_W-1:0];
        REG_LPS:     cfg.lines_per_step    <= pwdata[LPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_START_A: prdata = APB_DATA_W'(cfg.start_mix[0]);
      REG_START_B: prdata = APB_DATA_W'(cfg.start_mix[1]);
      REG_START_C: prdata = APB_DATA_W'(cfg.start_mix[2]);
      REG_END_A:   prdata = APB_DATA_W'(cfg.end_mix[0]);
      REG_END_B:   prdata = APB_DATA_W'(cfg.end_mix[1]);
      REG_END_C:   prdata = APB_DATA_W'(cfg.end_mix[2]);
      REG_LPS:     prdata = APB_DATA_W'(cfg.lines_per_step);
      default:     prdata = '0;
    endcase
  end

  twmrr_ramp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ramp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd_ch (cmd_ch),
    .mix_ch (mix_ch)
  );

endmodule
